@@ rtl/mfr_pkg.sv @@
`default_nettype none

package mfr_pkg;

    // receive phase; the spare code acts as idle
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_RAW   = 2'd2
    } phase_t;

    localparam logic [7:0]  FRAME_START    = 8'h68;
    localparam logic [7:0]  FRAME_END      = 8'h16;
    localparam logic [7:0]  RAW_START_A    = 8'hAB;
    localparam logic [7:0]  RAW_START_B    = 8'h01;
    localparam logic [7:0]  RAW_START_C    = 8'h02;
    localparam int          LEN_POS        = 10;
    localparam int          LEN_OVERHEAD   = 13;
    localparam int          IDX_W          = 9;
    localparam logic [IDX_W-1:0] LEN_MAX   = '1;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd50;
    localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;

    // one input word after the input register
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    // one result word
    typedef struct packed {
        logic             write_valid;
        logic [IDX_W-1:0] write_index;
        logic [7:0]       write_data;
        logic             frame_done;
        logic             raw_done;
        logic [IDX_W-1:0] done_length;
        logic             overflow;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/mfr_step.sv @@
`default_nettype none

module mfr_step
    import mfr_pkg::*;
#(
    parameter int BUF_DEPTH = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire item_t       item,
    input  wire logic [15:0] timeout_ticks,
    output result_t          result
);

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUF_DEPTH);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] frame_count_reg, frame_count_next;
    logic [CNT_W-1:0] raw_count_reg, raw_count_next;
    logic [15:0]      silence_reg, silence_next;
    logic [7:0]       length_reg, length_next;

    logic             is_byte, idle_like, in_frame, in_raw;
    logic             opens_frame, opens_raw;
    logic             byte_frame, byte_raw, full, store_ok;
    logic [CNT_W-1:0] store_cnt, cnt_inc;
    logic [7:0]       len_eff;
    logic [15:0]      silence_inc;
    logic             frame_end, raw_end;

    assign is_byte     = !item.mode;
    assign in_frame    = (phase_reg == PH_FRAME);
    assign in_raw      = (phase_reg == PH_RAW);
    assign idle_like   = !in_frame && !in_raw;
    assign opens_frame = idle_like && (item.rx_byte == FRAME_START);
    assign opens_raw   = idle_like && ((item.rx_byte == RAW_START_A)
                         || (item.rx_byte == RAW_START_B) || (item.rx_byte == RAW_START_C));
    assign byte_frame  = is_byte && (in_frame || opens_frame);
    assign byte_raw    = is_byte && (in_raw || opens_raw);

    assign store_cnt   = byte_frame ? frame_count_reg : raw_count_reg;
    assign full        = (store_cnt == CNT_FULL);
    assign store_ok    = (byte_frame || byte_raw) && !full;
    assign cnt_inc     = full ? store_cnt : store_cnt + CNT_W'(1);
    assign len_eff     = (store_ok && (store_cnt == CNT_W'(LEN_POS))) ? item.rx_byte
                                                                       : length_reg;

    assign frame_end   = in_frame && is_byte && (item.rx_byte == FRAME_END)
                         && (cnt_inc > CNT_W'(LEN_POS))
                         && (CMP_W'(cnt_inc) == CMP_W'(len_eff) + CMP_W'(LEN_OVERHEAD));

    assign silence_inc = (silence_reg == SILENCE_MAX) ? silence_reg : silence_reg + 16'd1;
    assign raw_end     = item.mode && in_raw && (silence_inc > timeout_ticks);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_FRAME:
            begin
                if (frame_end)
                    phase_next = PH_IDLE;
            end
            PH_RAW:
            begin
                if (raw_end)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                if (is_byte)
                begin
                    if (opens_frame)
                        phase_next = PH_FRAME;
                    else if (opens_raw)
                        phase_next = PH_RAW;
                    else
                        phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // counters and length byte
    always_comb
    begin
        frame_count_next = frame_count_reg;
        raw_count_next   = raw_count_reg;
        silence_next     = silence_reg;
        length_next      = len_eff;
        if (frame_end)
            frame_count_next = '0;
        else if (byte_frame)
            frame_count_next = cnt_inc;
        if (raw_end)
            raw_count_next = '0;
        else if (byte_raw)
            raw_count_next = cnt_inc;
        if (raw_end || byte_raw)
            silence_next = '0;
        else if (item.mode && in_raw)
            silence_next = silence_inc;
    end

    // result word
    always_comb
    begin
        result = '0;
        result.write_valid = store_ok;
        result.overflow    = (byte_frame || byte_raw) && full;
        result.frame_done  = frame_end;
        result.raw_done    = raw_end;
        if (store_ok)
        begin
            result.write_index = IDX_W'(store_cnt);
            result.write_data  = item.rx_byte;
        end
        if (frame_end)
            result.done_length = (CMP_W'(cnt_inc) > CMP_W'(LEN_MAX)) ? LEN_MAX
                                                                     : IDX_W'(cnt_inc);
        else if (raw_end)
            result.done_length = (CMP_W'(raw_count_reg) > CMP_W'(LEN_MAX)) ? LEN_MAX
                                                                           : IDX_W'(raw_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            frame_count_reg <= '0;
            raw_count_reg   <= '0;
            silence_reg     <= '0;
            length_reg      <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            frame_count_reg <= frame_count_next;
            raw_count_reg   <= raw_count_next;
            silence_reg     <= silence_next;
            length_reg      <= length_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/meter_frame_and_idle_timeout_receiver.sv @@
// path: an accepted word is held in the input register, then its result word in the
//   result register; throughput: one word per cycle while out_stall is low, set by
//   the single-pass step logic between the input register and the result register
// reset: asynchronous active low; idle phase, counters and length cleared,
//   timeout register back to 50 ticks, no word held in either register
`default_nettype none

module meter_frame_and_idle_timeout_receiver
    import mfr_pkg::*;
#(
    parameter int BUF_DEPTH = 512
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input words
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             mode,
    input  wire logic [7:0]       rx_byte,
    // timeout register write
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [15:0]      cfg_data,
    // result words
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  write_valid,
    output logic [IDX_W-1:0]      write_index,
    output logic [7:0]            write_data,
    output logic                  frame_done,
    output logic                  raw_done,
    output logic [IDX_W-1:0]      done_length,
    output logic                  overflow
);

    logic        s1_valid_reg, s1_valid_next;
    item_t       s1_item_reg;
    logic        out_valid_reg;
    result_t     out_reg, step_result;
    logic [15:0] timeout_reg;
    logic        advance, in_fire, step_en;

    // the result register frees up when empty or being taken
    assign advance   = !out_valid_reg || !out_stall;
    // input register holds while its word cannot move on
    assign in_stall  = s1_valid_reg && !advance;
    assign in_fire   = in_valid && !in_stall;
    assign step_en   = s1_valid_reg && advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.mode    <= mode;
            s1_item_reg.rx_byte <= rx_byte;
        end
    end

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_valid && cfg_ready)
            timeout_reg <= cfg_data;
    end

    // per-word state update and result
    mfr_step #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .item          (s1_item_reg),
        .timeout_ticks (timeout_reg),
        .result        (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_reg <= step_result;
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = out_reg.write_valid;
    assign write_index = out_reg.write_index;
    assign write_data  = out_reg.write_data;
    assign frame_done  = out_reg.frame_done;
    assign raw_done    = out_reg.raw_done;
    assign done_length = out_reg.done_length;
    assign overflow    = out_reg.overflow;

    // a word is never both stored and dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.write_valid && out_reg.overflow))
        else $error("write and overflow in one word");

    // only one kind of ending per word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.frame_done && out_reg.raw_done))
        else $error("frame and raw ending together");

    // length is reported only with an ending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.frame_done && !out_reg.raw_done)
            |-> (out_reg.done_length == '0))
        else $error("length without an ending");

    // a stalled result word stays put (the input register is held too, but unchecked here)
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result word lost");

    // input stalls only while a word waits in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with nothing held");

endmodule

`default_nettype wire
